FILE: design/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

  localparam int IDX_W     = 9;
  localparam int COUNT_W   = 9;
  localparam int RAD_W     = 16;
  localparam int POS_W     = 17;
  localparam int NORM_W    = 16;
  localparam int TEX_W     = 17;
  localparam int VTX_W     = 17;
  localparam int REM_W     = 10;
  localparam int SEC_Q_W   = 33;
  localparam int STK_Q_W   = 32;
  localparam int PH_W      = 32;
  localparam int CW        = 34;
  localparam int SC_W      = 16;
  localparam int ATAN_LEN  = 24;
  localparam int DIV_STEPS = 33;
  localparam int TEX_STEP  = 16;
  localparam int STK_STEP  = 31;
  localparam int SEC_STEP  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECTORS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS  = 2'd2;

  localparam logic [RAD_W-1:0]   RADIUS_RST  = 16'd256;
  localparam logic [COUNT_W-1:0] SECTORS_RST = 9'd36;
  localparam logic [COUNT_W-1:0] STACKS_RST  = 9'd18;

  localparam logic [PH_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [PH_W-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic             upper;
    logic             lower;
    logic [VTX_W-1:0] corner;
    logic [VTX_W-1:0] below;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [REM_W-1:0]   sec_rem;
    logic [REM_W-1:0]   stk_rem;
    logic [SEC_Q_W-1:0] sec_q;
    logic [STK_Q_W-1:0] stk_q;
    logic [TEX_W-1:0]   tex_u;
    logic [TEX_W-1:0]   tex_v;
    logic [PH_W-1:0]    sec_ph;
    logic [PH_W-1:0]    stk_ph;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 neg;
  } rot_t;

  typedef struct packed {
    side_t            side;
    logic [TEX_W-1:0] tex_u;
    logic [TEX_W-1:0] tex_v;
    rot_t             stk;
    rot_t             sec;
  } cor_t;

  function automatic logic signed [CW-1:0] atan_phase(input int k);
    logic signed [CW-1:0] a;
    case (k)
      0:       a = 34'sd536870912;
      1:       a = 34'sd316933406;
      2:       a = 34'sd167458907;
      3:       a = 34'sd85004756;
      4:       a = 34'sd42667331;
      5:       a = 34'sd21354465;
      6:       a = 34'sd10679838;
      7:       a = 34'sd5340245;
      8:       a = 34'sd2670163;
      9:       a = 34'sd1335087;
      10:      a = 34'sd667544;
      11:      a = 34'sd333772;
      12:      a = 34'sd166886;
      13:      a = 34'sd83443;
      14:      a = 34'sd41722;
      15:      a = 34'sd20861;
      16:      a = 34'sd10430;
      17:      a = 34'sd5215;
      18:      a = 34'sd2608;
      19:      a = 34'sd1304;
      20:      a = 34'sd652;
      21:      a = 34'sd326;
      22:      a = 34'sd163;
      23:      a = 34'sd81;
      default: a = 34'sd0;
    endcase
    return a;
  endfunction

endpackage
`default_nettype wire

FILE: design/uvs_req_if.sv
`default_nettype none
interface uvs_req_if;
  logic                      valid;
  logic                      ready;
  logic [uvs_pkg::IDX_W-1:0] stack_index;
  logic [uvs_pkg::IDX_W-1:0] sector_index;

  modport source (output valid, stack_index, sector_index, input ready);
  modport sink (input valid, stack_index, sector_index, output ready);
endinterface
`default_nettype wire

FILE: design/uvs_res_if.sv
`default_nettype none
interface uvs_res_if;
  logic                              valid;
  logic                              ready;
  logic signed [uvs_pkg::POS_W-1:0]  pos_x;
  logic signed [uvs_pkg::POS_W-1:0]  pos_y;
  logic signed [uvs_pkg::POS_W-1:0]  pos_z;
  logic signed [uvs_pkg::NORM_W-1:0] norm_x;
  logic signed [uvs_pkg::NORM_W-1:0] norm_y;
  logic signed [uvs_pkg::NORM_W-1:0] norm_z;
  logic [uvs_pkg::TEX_W-1:0]         tex_u;
  logic [uvs_pkg::TEX_W-1:0]         tex_v;
  logic                              upper_tri_valid;
  logic                              lower_tri_valid;
  logic [uvs_pkg::VTX_W-1:0]         corner_vertex;
  logic [uvs_pkg::VTX_W-1:0]         below_vertex;

  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                  upper_tri_valid, lower_tri_valid, corner_vertex, below_vertex,
                  input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
                upper_tri_valid, lower_tri_valid, corner_vertex, below_vertex,
                output ready);
endinterface
`default_nettype wire

FILE: design/uvs_cfg_if.sv
`default_nettype none
interface uvs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [uvs_pkg::CFG_IDX_W-1:0]  index;
  logic [uvs_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: design/uvs_div_cell.sv
`default_nettype none
module uvs_div_cell #(
  parameter int STEP = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [uvs_pkg::COUNT_W-1:0] sec_n,
  input  wire logic [uvs_pkg::COUNT_W-1:0] stk_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire uvs_pkg::div_t               in_data,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output uvs_pkg::div_t                    out_data
);

  logic                        en;
  uvs_pkg::div_t               d;
  logic [uvs_pkg::REM_W-1:0]   sec_t;
  logic [uvs_pkg::REM_W-1:0]   stk_t;
  logic [uvs_pkg::REM_W-1:0]   sec_nw;
  logic [uvs_pkg::REM_W-1:0]   stk_nw;
  logic [uvs_pkg::REM_W-1:0]   sec_half;
  logic [uvs_pkg::REM_W-1:0]   stk_half;
  logic                        sec_bit;
  logic                        stk_bit;
  logic                        sec_rnd;
  logic                        stk_rnd;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    d        = in_data;
    sec_nw   = {1'b0, sec_n};
    stk_nw   = {1'b0, stk_n};
    sec_half = (sec_nw + 10'd1) >> 1;
    stk_half = (stk_nw + 10'd1) >> 1;
    sec_t    = (STEP == 0) ? in_data.sec_rem : {in_data.sec_rem[uvs_pkg::REM_W-2:0], 1'b0};
    stk_t    = (STEP == 0) ? in_data.stk_rem : {in_data.stk_rem[uvs_pkg::REM_W-2:0], 1'b0};
    sec_bit  = sec_t >= sec_nw;
    stk_bit  = stk_t >= stk_nw;
    d.sec_rem = sec_bit ? sec_t - sec_nw : sec_t;
    d.sec_q   = {in_data.sec_q[uvs_pkg::SEC_Q_W-2:0], sec_bit};
    if (STEP <= uvs_pkg::STK_STEP) begin
      d.stk_rem = stk_bit ? stk_t - stk_nw : stk_t;
      d.stk_q   = {in_data.stk_q[uvs_pkg::STK_Q_W-2:0], stk_bit};
    end
    sec_rnd = d.sec_rem >= sec_half;
    stk_rnd = d.stk_rem >= stk_half;
    if (STEP == uvs_pkg::TEX_STEP) begin
      d.tex_u = d.sec_q[uvs_pkg::TEX_W-1:0] + {16'd0, sec_rnd};
      d.tex_v = d.stk_q[uvs_pkg::TEX_W-1:0] + {16'd0, stk_rnd};
    end
    if (STEP == uvs_pkg::STK_STEP) begin
      d.stk_ph = uvs_pkg::QUARTER_TURN - (d.stk_q + {31'd0, stk_rnd});
    end
    if (STEP == uvs_pkg::SEC_STEP) begin
      d.sec_ph = d.sec_q[uvs_pkg::PH_W-1:0] + {31'd0, sec_rnd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d;
    end
  end

endmodule
`default_nettype wire

FILE: design/uvs_cordic_cell.sv
`default_nettype none
module uvs_cordic_cell #(
  parameter int K = 0
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire uvs_pkg::cor_t in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output uvs_pkg::cor_t      out_data
);

  logic          en;
  uvs_pkg::cor_t d;

  function automatic uvs_pkg::rot_t rotate(input uvs_pkg::rot_t r);
    uvs_pkg::rot_t        o;
    logic signed [uvs_pkg::CW-1:0] xs;
    logic signed [uvs_pkg::CW-1:0] ys;
    o  = r;
    xs = r.x >>> K;
    ys = r.y >>> K;
    if (!r.z[uvs_pkg::CW-1]) begin
      o.x = r.x - ys;
      o.y = r.y + xs;
      o.z = r.z - uvs_pkg::atan_phase(K);
    end else begin
      o.x = r.x + ys;
      o.y = r.y - xs;
      o.z = r.z + uvs_pkg::atan_phase(K);
    end
    return o;
  endfunction

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    d     = in_data;
    d.stk = rotate(in_data.stk);
    d.sec = rotate(in_data.sec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= d;
    end
  end

endmodule
`default_nettype wire

FILE: design/uv_sphere_vertex_generator.sv
// UV sphere vertex generator: one request per (stack, sector) grid point gives position,
// normal, texture coordinates, quad vertex indices and the two triangle flags. It takes one
// request every cycle unless the result side stalls; a request passes through the input
// register, the 33-cell long-division chain for the angles and texture coordinates, the CORDIC
// cell chain and the fold, rounding and multiply stages. Write configuration only while idle.
`default_nettype none
module uv_sphere_vertex_generator #(
  parameter int MAX_SECTORS   = 256,
  parameter int MAX_STACKS    = 256,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  uvs_req_if.sink    req,
  uvs_res_if.source  res,
  uvs_cfg_if.sink    cfg
);

  localparam int NS = uvs_pkg::DIV_STEPS;
  localparam int NC = CORDIC_STAGES;

  typedef struct packed {
    uvs_pkg::side_t                         side;
    logic [uvs_pkg::TEX_W-1:0]              tex_u;
    logic [uvs_pkg::TEX_W-1:0]              tex_v;
    logic signed [uvs_pkg::SC_W-1:0]        st;
    logic signed [uvs_pkg::SC_W-1:0]        ct;
    logic signed [uvs_pkg::SC_W-1:0]        sp;
    logic signed [uvs_pkg::SC_W-1:0]        cp;
  } trig_t;

  typedef struct packed {
    uvs_pkg::side_t                         side;
    logic [uvs_pkg::TEX_W-1:0]              tex_u;
    logic [uvs_pkg::TEX_W-1:0]              tex_v;
    logic signed [31:0]                     cc;
    logic signed [31:0]                     cs;
    logic signed [32:0]                     pz;
    logic signed [uvs_pkg::NORM_W-1:0]      nz;
  } prod_t;

  typedef struct packed {
    uvs_pkg::side_t                         side;
    logic [uvs_pkg::TEX_W-1:0]              tex_u;
    logic [uvs_pkg::TEX_W-1:0]              tex_v;
    logic signed [48:0]                     px;
    logic signed [48:0]                     py;
    logic signed [uvs_pkg::POS_W-1:0]       pos_z;
    logic signed [uvs_pkg::NORM_W-1:0]      nx;
    logic signed [uvs_pkg::NORM_W-1:0]      ny;
    logic signed [uvs_pkg::NORM_W-1:0]      nz;
  } scale_t;

  logic [uvs_pkg::RAD_W-1:0]   radius;
  logic [uvs_pkg::COUNT_W-1:0] sector_count;
  logic [uvs_pkg::COUNT_W-1:0] stack_count;
  logic [uvs_pkg::COUNT_W-1:0] n_eff;
  logic [uvs_pkg::COUNT_W-1:0] s_eff;

  logic                        dv    [NS+1];
  uvs_pkg::div_t               dd    [NS+1];
  logic                        dtake [NS+1];
  logic                        cv    [NC+1];
  uvs_pkg::cor_t               cd    [NC+1];
  logic                        ctake [NC+1];

  logic                        en_f;
  uvs_pkg::div_t               front_next;
  logic [uvs_pkg::IDX_W-1:0]   i_c;
  logic [uvs_pkg::IDX_W-1:0]   j_c;
  logic [18:0]                 corner_full;
  logic [uvs_pkg::VTX_W-1:0]   corner;

  uvs_pkg::cor_t               fold_next;
  logic                        v_trig;
  logic                        en_trig;
  trig_t                       trig;
  trig_t                       trig_next;
  logic                        v_prod;
  logic                        en_prod;
  prod_t                       prod;
  prod_t                       prod_next;
  logic                        v_scale;
  logic                        en_scale;
  scale_t                      scale;
  scale_t                      scale_next;
  logic                        en_out;
  logic signed [16:0]          r_s;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius       <= uvs_pkg::RADIUS_RST;
      sector_count <= uvs_pkg::SECTORS_RST;
      stack_count  <= uvs_pkg::STACKS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        uvs_pkg::REG_RADIUS:  radius       <= cfg.data;
        uvs_pkg::REG_SECTORS: sector_count <= cfg.data[uvs_pkg::COUNT_W-1:0];
        uvs_pkg::REG_STACKS:  stack_count  <= cfg.data[uvs_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (sector_count < 9'd3) begin
      n_eff = 9'd3;
    end else if (32'(sector_count) > MAX_SECTORS) begin
      n_eff = uvs_pkg::COUNT_W'(MAX_SECTORS);
    end else begin
      n_eff = sector_count;
    end
    if (stack_count < 9'd2) begin
      s_eff = 9'd2;
    end else if (32'(stack_count) > MAX_STACKS) begin
      s_eff = uvs_pkg::COUNT_W'(MAX_STACKS);
    end else begin
      s_eff = stack_count;
    end
  end

  always_comb begin
    i_c         = (req.stack_index > s_eff) ? s_eff : req.stack_index;
    j_c         = (req.sector_index > n_eff) ? n_eff : req.sector_index;
    corner_full = 19'(i_c * ({1'b0, n_eff} + 10'd1)) + {10'd0, j_c};
    corner      = corner_full[uvs_pkg::VTX_W-1:0];
    front_next  = '0;
    front_next.side.upper  = (i_c != 9'd0) && (i_c < s_eff) && (j_c < n_eff);
    front_next.side.lower  = (i_c != s_eff - 9'd1) && (i_c < s_eff) && (j_c < n_eff);
    front_next.side.corner = corner;
    front_next.side.below  = corner + {8'd0, n_eff} + 17'd1;
    front_next.sec_rem     = {1'b0, j_c};
    front_next.stk_rem     = {1'b0, i_c};
  end

  assign en_f      = !dv[0] || dtake[0];
  assign req.ready = en_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en_f) begin
      dv[0] <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_f) begin
      dd[0] <= front_next;
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_div
    uvs_div_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .sec_n     (n_eff),
      .stk_n     (s_eff),
      .in_valid  (dv[k]),
      .in_ready  (dtake[k]),
      .in_data   (dd[k]),
      .out_valid (dv[k+1]),
      .out_ready (dtake[k+1]),
      .out_data  (dd[k+1])
    );
  end

  function automatic uvs_pkg::rot_t fold(input logic [uvs_pkg::PH_W-1:0] ph);
    uvs_pkg::rot_t             r;
    logic [uvs_pkg::PH_W-1:0]  t;
    logic [uvs_pkg::PH_W-1:0]  p;
    t     = ph + uvs_pkg::QUARTER_TURN;
    p     = t[uvs_pkg::PH_W-1] ? ph - uvs_pkg::HALF_TURN : ph;
    r.neg = t[uvs_pkg::PH_W-1];
    r.x   = uvs_pkg::CORDIC_X0;
    r.y   = '0;
    r.z   = {{(uvs_pkg::CW - uvs_pkg::PH_W){p[uvs_pkg::PH_W-1]}}, p};
    return r;
  endfunction

  always_comb begin
    fold_next.side  = dd[NS].side;
    fold_next.tex_u = dd[NS].tex_u;
    fold_next.tex_v = dd[NS].tex_v;
    fold_next.stk   = fold(dd[NS].stk_ph);
    fold_next.sec   = fold(dd[NS].sec_ph);
  end

  assign dtake[NS] = !cv[0] || ctake[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (dtake[NS]) begin
      cv[0] <= dv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (dtake[NS]) begin
      cd[0] <= fold_next;
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_cordic
    uvs_cordic_cell #(.K(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (ctake[k]),
      .in_data   (cd[k]),
      .out_valid (cv[k+1]),
      .out_ready (ctake[k+1]),
      .out_data  (cd[k+1])
    );
  end

  function automatic logic signed [uvs_pkg::SC_W-1:0] to_q14(
    input logic signed [uvs_pkg::CW-1:0] v,
    input logic                          neg
  );
    logic signed [uvs_pkg::CW-1:0]  t;
    logic signed [uvs_pkg::CW-17:0] r;
    logic signed [uvs_pkg::SC_W-1:0] s;
    t = v + 34'sd32768;
    r = t[uvs_pkg::CW-1:16];
    if (r > 18'sd16384) begin
      s = 16'sd16384;
    end else if (r < -18'sd16384) begin
      s = -16'sd16384;
    end else begin
      s = r[uvs_pkg::SC_W-1:0];
    end
    return neg ? -s : s;
  endfunction

  always_comb begin
    trig_next.side  = cd[NC].side;
    trig_next.tex_u = cd[NC].tex_u;
    trig_next.tex_v = cd[NC].tex_v;
    trig_next.st    = to_q14(cd[NC].stk.y, cd[NC].stk.neg);
    trig_next.ct    = to_q14(cd[NC].stk.x, cd[NC].stk.neg);
    trig_next.sp    = to_q14(cd[NC].sec.y, cd[NC].sec.neg);
    trig_next.cp    = to_q14(cd[NC].sec.x, cd[NC].sec.neg);
  end

  assign en_trig   = !v_trig || en_prod;
  assign ctake[NC] = en_trig;
  assign r_s       = {1'b0, radius};

  always_comb begin
    prod_next.side  = trig.side;
    prod_next.tex_u = trig.tex_u;
    prod_next.tex_v = trig.tex_v;
    prod_next.cc    = trig.ct * trig.cp;
    prod_next.cs    = trig.ct * trig.sp;
    prod_next.pz    = r_s * trig.st;
    prod_next.nz    = trig.st;
  end

  function automatic logic signed [uvs_pkg::NORM_W-1:0] norm_round(
    input logic signed [31:0] v
  );
    logic signed [31:0] t;
    logic signed [17:0] r;
    logic signed [uvs_pkg::NORM_W-1:0] o;
    t = v + 32'sd8192;
    r = t[31:14];
    if (r > 18'sd16384) begin
      o = 16'sd16384;
    end else if (r < -18'sd16384) begin
      o = -16'sd16384;
    end else begin
      o = r[uvs_pkg::NORM_W-1:0];
    end
    return o;
  endfunction

  always_comb begin
    logic signed [32:0] tz;
    logic signed [18:0] rz;
    tz = prod.pz + 33'sd8192;
    rz = tz[32:14];
    scale_next.side  = prod.side;
    scale_next.tex_u = prod.tex_u;
    scale_next.tex_v = prod.tex_v;
    scale_next.px    = r_s * prod.cc;
    scale_next.py    = r_s * prod.cs;
    scale_next.nx    = norm_round(prod.cc);
    scale_next.ny    = norm_round(prod.cs);
    scale_next.nz    = prod.nz;
    if (rz > 19'sd65535) begin
      scale_next.pos_z = 17'sd65535;
    end else if (rz < -19'sd65535) begin
      scale_next.pos_z = -17'sd65535;
    end else begin
      scale_next.pos_z = rz[uvs_pkg::POS_W-1:0];
    end
  end

  function automatic logic signed [uvs_pkg::POS_W-1:0] pos_round(
    input logic signed [48:0] v
  );
    logic signed [48:0] t;
    logic signed [20:0] r;
    logic signed [uvs_pkg::POS_W-1:0] o;
    t = v + 49'sd134217728;
    r = t[48:28];
    if (r > 21'sd65535) begin
      o = 17'sd65535;
    end else if (r < -21'sd65535) begin
      o = -17'sd65535;
    end else begin
      o = r[uvs_pkg::POS_W-1:0];
    end
    return o;
  endfunction

  assign en_prod  = !v_prod || en_scale;
  assign en_scale = !v_scale || en_out;
  assign en_out   = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_trig    <= 1'b0;
      v_prod    <= 1'b0;
      v_scale   <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (en_trig) begin
        v_trig <= cv[NC];
      end
      if (en_prod) begin
        v_prod <= v_trig;
      end
      if (en_scale) begin
        v_scale <= v_prod;
      end
      if (en_out) begin
        res.valid <= v_scale;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_trig) begin
      trig <= trig_next;
    end
    if (en_prod) begin
      prod <= prod_next;
    end
    if (en_scale) begin
      scale <= scale_next;
    end
    if (en_out) begin
      res.pos_x           <= pos_round(scale.px);
      res.pos_y           <= pos_round(scale.py);
      res.pos_z           <= scale.pos_z;
      res.norm_x          <= scale.nx;
      res.norm_y          <= scale.ny;
      res.norm_z          <= scale.nz;
      res.tex_u           <= scale.tex_u;
      res.tex_v           <= scale.tex_v;
      res.upper_tri_valid <= scale.side.upper;
      res.lower_tri_valid <= scale.side.lower;
      res.corner_vertex   <= scale.side.corner;
      res.below_vertex    <= scale.side.below;
    end
  end

endmodule
`default_nettype wire

FILE: sim/uv_sphere_vertex_generator_tb.sv
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_tb;

  localparam int NSTAGE = 16;
  localparam int LATENCY = NSTAGE + 39;
  localparam int WATCHDOG = 20000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [uvs_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [uvs_pkg::IDX_W-1:0] stk;
    logic [uvs_pkg::IDX_W-1:0] sec;
  } grid_pt_t;

  typedef struct {
    logic signed [uvs_pkg::POS_W-1:0]  px, py, pz;
    logic signed [uvs_pkg::NORM_W-1:0] nx, ny, nz;
    logic [uvs_pkg::TEX_W-1:0]         u, v;
    logic                              up, lo;
    logic [uvs_pkg::VTX_W-1:0]         corner, below;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  uvs_req_if req ();
  uvs_res_if res ();
  uvs_cfg_if cfg ();

  uv_sphere_vertex_generator dut (
    .clk(clk), .rst(rst), .req(req.sink), .res(res.source), .cfg(cfg.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  grid_pt_t pending_pts[$];
  vertex_t  expected_verts[$];
  int       errors = 0;
  int       sent = 0;
  int       received = 0;
  int       settings_used = 0;
  int       idle_cycles = 0;
  bit       hold_arm = 1'b0;
  bit       hold_seen = 1'b0;
  int       hold_left = 0;

  logic [uvs_pkg::RAD_W-1:0]   cur_radius = uvs_pkg::RADIUS_RST;
  logic [uvs_pkg::COUNT_W-1:0] cur_sectors = uvs_pkg::SECTORS_RST;
  logic [uvs_pkg::COUNT_W-1:0] cur_stacks = uvs_pkg::STACKS_RST;

  int      req_gap = 0;
  int      res_stall = 0;

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint round_shr(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clip(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint turn_angle(int k);
    longint t [24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
    return t[k];
  endfunction

  task automatic rotate_phase(input logic [31:0] phase, output longint s, output longint c);
    bit     flip;
    longint x, y, z, xn;
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (((phase + 32'h4000_0000) >> 31) & 1) begin
      phase = phase - 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'(signed'(phase));
    for (int k = 0; k < NSTAGE; k++) begin
      if (z >= 0) begin
        xn = x - floor_shr(y, k);
        y = y + floor_shr(x, k);
        z = z - turn_angle(k);
      end else begin
        xn = x + floor_shr(y, k);
        y = y - floor_shr(x, k);
        z = z + turn_angle(k);
      end
      x = xn;
    end
    x = clip(round_shr(x, 16), 16384);
    y = clip(round_shr(y, 16), 16384);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_vertex(input grid_pt_t p, output vertex_t e);
    longint n, s, i, j, r, st, ct, sp, cp, cc, cs, corner;
    logic [31:0] ph_sec, ph_stk;
    n = cur_sectors;
    s = cur_stacks;
    r = cur_radius;
    i = p.stk;
    j = p.sec;
    if (n < 3) n = 3;
    if (n > 256) n = 256;
    if (s < 2) s = 2;
    if (s > 256) s = 256;
    if (i > s) i = s;
    if (j > n) j = n;
    ph_sec = 32'(((j << 32) + n / 2) / n);
    ph_stk = 32'h4000_0000 - 32'(((i << 31) + s / 2) / s);
    rotate_phase(ph_stk, st, ct);
    rotate_phase(ph_sec, sp, cp);
    cc = ct * cp;
    cs = ct * sp;
    e.px = uvs_pkg::POS_W'(clip(round_shr(r * cc, 28), 65535));
    e.py = uvs_pkg::POS_W'(clip(round_shr(r * cs, 28), 65535));
    e.pz = uvs_pkg::POS_W'(clip(round_shr(r * st, 14), 65535));
    e.nx = uvs_pkg::NORM_W'(clip(round_shr(cc, 14), 16384));
    e.ny = uvs_pkg::NORM_W'(clip(round_shr(cs, 14), 16384));
    e.nz = uvs_pkg::NORM_W'(st);
    e.u = uvs_pkg::TEX_W'(((j << 16) + n / 2) / n);
    e.v = uvs_pkg::TEX_W'(((i << 16) + s / 2) / s);
    e.up = (i != 0 && i < s && j < n);
    e.lo = (i != s - 1 && i < s && j < n);
    corner = i * (n + 1) + j;
    e.corner = uvs_pkg::VTX_W'(corner);
    e.below = uvs_pkg::VTX_W'(corner + n + 1);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // request driver
  always @(posedge clk) begin
    vertex_t exp_v;
    if (rst) begin
      req.valid <= 1'b0;
      req.stack_index <= '0;
      req.sector_index <= '0;
      req_gap <= 0;
    end else begin
      if (req.valid && req.ready) begin
        predict_vertex({req.stack_index, req.sector_index}, exp_v);
        expected_verts.insert(expected_verts.size(), exp_v);
        sent <= sent + 1;
      end
      if (!req.valid || req.ready) begin
        if (req_gap > 0 || pending_pts.size() == 0) begin
          req.valid <= 1'b0;
          if (req_gap > 0) req_gap <= req_gap - 1;
        end else begin
          grid_pt_t p;
          p = pending_pts.pop_front();
          req.valid <= 1'b1;
          req.stack_index <= p.stk;
          req.sector_index <= p.sec;
          req_gap <= pick_gap();
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      res_stall <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        received <= received + 1;
        if (expected_verts.size() == 0) begin
          $error("unexpected result");
          errors <= errors + 1;
        end else begin
          vertex_t e;
          int bad;
          e = expected_verts.pop_front();
          bad = 0;
          if (res.pos_x !== e.px) begin
            $error("pos_x exp %0d got %0d", e.px, res.pos_x); bad++; end
          if (res.pos_y !== e.py) begin
            $error("pos_y exp %0d got %0d", e.py, res.pos_y); bad++; end
          if (res.pos_z !== e.pz) begin
            $error("pos_z exp %0d got %0d", e.pz, res.pos_z); bad++; end
          if (res.norm_x !== e.nx) begin
            $error("norm_x exp %0d got %0d", e.nx, res.norm_x); bad++; end
          if (res.norm_y !== e.ny) begin
            $error("norm_y exp %0d got %0d", e.ny, res.norm_y); bad++; end
          if (res.norm_z !== e.nz) begin
            $error("norm_z exp %0d got %0d", e.nz, res.norm_z); bad++; end
          if (res.tex_u !== e.u) begin
            $error("tex_u exp %0d got %0d", e.u, res.tex_u); bad++; end
          if (res.tex_v !== e.v) begin
            $error("tex_v exp %0d got %0d", e.v, res.tex_v); bad++; end
          if (res.upper_tri_valid !== e.up) begin
            $error("upper_tri_valid exp %0d got %0d", e.up, res.upper_tri_valid); bad++; end
          if (res.lower_tri_valid !== e.lo) begin
            $error("lower_tri_valid exp %0d got %0d", e.lo, res.lower_tri_valid); bad++; end
          if (res.corner_vertex !== e.corner) begin
            $error("corner_vertex exp %0d got %0d", e.corner, res.corner_vertex); bad++; end
          if (res.below_vertex !== e.below) begin
            $error("below_vertex exp %0d got %0d", e.below, res.below_vertex); bad++; end
          errors <= errors + bad;
        end
      end
      if (hold_left > 0) begin
        res.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_arm && !hold_seen) begin
        res.ready <= 1'b0;
        hold_seen <= 1'b1;
        hold_left <= HOLD_CYCLES;
      end else if (res_stall > 0) begin
        res.ready <= 1'b0;
        res_stall <= res_stall - 1;
      end else begin
        res.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) res_stall <= pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready)
        || hold_left != 0)
      idle_cycles <= 0;
    else if (pending_pts.size() != 0 || expected_verts.size() != 0 || req.valid) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [uvs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [uvs_pkg::CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
    case (idx)
      uvs_pkg::REG_RADIUS:  cur_radius = val;
      uvs_pkg::REG_SECTORS: cur_sectors = val[uvs_pkg::COUNT_W-1:0];
      uvs_pkg::REG_STACKS:  cur_stacks = val[uvs_pkg::COUNT_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_pts.size() != 0 || req.valid || expected_verts.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic add_pt(input int i, input int j);
    grid_pt_t p;
    p.stk = uvs_pkg::IDX_W'(i);
    p.sec = uvs_pkg::IDX_W'(j);
    pending_pts.insert(pending_pts.size(), p);
  endtask

  task automatic random_batch(input int count);
    int n, s;
    n = cur_sectors < 3 ? 3 : cur_sectors;
    s = cur_stacks < 2 ? 2 : cur_stacks;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) < 8)
        add_pt($urandom_range(0, s), $urandom_range(0, n));
      else
        add_pt($urandom_range(0, 511), $urandom_range(0, 511));
    end
  endtask

  task automatic configure(input int r, input int n, input int s);
    write_reg(uvs_pkg::REG_RADIUS, uvs_pkg::CFG_DATA_W'(r));
    write_reg(uvs_pkg::REG_SECTORS, uvs_pkg::CFG_DATA_W'(n));
    write_reg(uvs_pkg::REG_STACKS, uvs_pkg::CFG_DATA_W'(s));
    settings_used++;
  endtask

  initial begin
    cfg.valid = 1'b0;
    cfg.index = '0;
    cfg.data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: poles, edges, out-of-range indexes
    add_pt(0, 0);
    add_pt(18, 0);
    add_pt(17, 35);
    add_pt(1, 36);
    add_pt(9, 9);
    add_pt(511, 511);
    add_pt(256, 256);
    add_pt(0, 18);
    add_pt(9, 27);
    drain();

    configure(0, 3, 2);
    add_pt(0, 0); add_pt(1, 1); add_pt(2, 2); add_pt(1, 3); add_pt(3, 5);
    drain();

    configure(65535, 256, 256);
    add_pt(0, 0); add_pt(128, 64); add_pt(255, 255); add_pt(256, 256);
    add_pt(170, 85); add_pt(85, 170); add_pt(200, 300);
    drain();

    // out-of-range counts are clamped; an index beyond the list is ignored
    configure(1, 0, 511);
    write_reg(REG_UNUSED, 16'hFFFF);
    add_pt(1, 2); add_pt(255, 1); add_pt(300, 4);
    drain();

    configure(256, 36, 18);
    hold_arm = 1'b1;
    random_batch(150);
    while (!hold_seen || hold_left != 0) @(posedge clk);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      configure($urandom_range(1, 65535), $urandom_range(3, 256), $urandom_range(2, 256));
      random_batch(120);
      drain();
    end
    configure(65535, $urandom_range(0, 511), $urandom_range(0, 511));
    random_batch(100);
    drain();
    configure(256, 4, 2);
    random_batch(100);
    drain();

    $display("Covered %0d vertex requests and %0d results over %0d register settings.",
             sent, received, settings_used);
    if (errors == 0 && expected_verts.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end
endmodule
